>>> rtl/cfd_pkg.sv
package cfd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CFG_IDX_W = 4;

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
	localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_TYPE = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_TYPE = 4'd3;

	localparam logic [BYTE_W-1:0] RST_SYNC_FIRST = 8'hAA;
	localparam logic [BYTE_W-1:0] RST_SYNC_SECOND = 8'h55;
	localparam logic [BYTE_W-1:0] RST_DATA_TYPE = 8'h01;
	localparam logic [BYTE_W-1:0] RST_ACK_TYPE = 8'h02;

	typedef enum logic [2:0] {
		PH_SYNC_A = 3'd0,
		PH_SYNC_B = 3'd1,
		PH_KIND = 3'd2,
		PH_SEQ = 3'd3,
		PH_CMD = 3'd4,
		PH_CHECK = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_NONE = 2'd0,
		ST_OK = 2'd1,
		ST_ERR = 2'd2
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] sync_first;
		logic [BYTE_W-1:0] sync_second;
		logic [BYTE_W-1:0] data_type_code;
		logic [BYTE_W-1:0] ack_type_code;
	} cfg_t;

	typedef struct packed {
		status_t status;
		logic [BYTE_W-1:0] kind;
		logic [BYTE_W-1:0] seq;
		logic [BYTE_W-1:0] cmd;
	} res_t;

	// one byte of CRC-8, MSB first
	function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] acc,
			input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] c;
		c = acc ^ b;
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/cfd_parse.sv
module cfd_parse (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [cfd_pkg::BYTE_W-1:0]   rx_byte,
	input  cfd_pkg::cfg_t                cfg,
	output cfd_pkg::res_t                res
);
	import cfd_pkg::*;

	phase_t phase_q, phase_d;
	logic [BYTE_W-1:0] kind_q, seq_q, cmd_q, crc_q;
	logic [BYTE_W-1:0] crc_next;
	logic kind_known;

	// running CRC: one byte folded in per captured field
	assign crc_next = crc8_byte((phase_q == PH_KIND) ? CRC_INIT : crc_q, rx_byte);
	assign kind_known = (kind_q == cfg.data_type_code) || (kind_q == cfg.ack_type_code);

	always_comb begin
		phase_d = PH_SYNC_A;
		res = '{status: ST_NONE, kind: '0, seq: '0, cmd: '0};
		case (phase_q)
			PH_SYNC_A: begin
				if (rx_byte == cfg.sync_first) phase_d = PH_SYNC_B;
			end
			PH_SYNC_B: begin
				if (rx_byte == cfg.sync_second) phase_d = PH_KIND;
				else if (rx_byte == cfg.sync_first) phase_d = PH_SYNC_B;
			end
			PH_KIND: phase_d = PH_SEQ;
			PH_SEQ: phase_d = PH_CMD;
			PH_CMD: phase_d = PH_CHECK;
			PH_CHECK: begin
				if (crc_q != rx_byte || !kind_known) begin
					res.status = ST_ERR;
				end else begin
					res = '{status: ST_OK, kind: kind_q, seq: seq_q, cmd: cmd_q};
				end
			end
			default: res.status = ST_ERR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC_A;
			kind_q <= '0;
			seq_q <= '0;
			cmd_q <= '0;
			crc_q <= CRC_INIT;
		end else if (step) begin
			phase_q <= phase_d;
			if (phase_q == PH_KIND) kind_q <= rx_byte;
			if (phase_q == PH_SEQ) seq_q <= rx_byte;
			if (phase_q == PH_CMD) cmd_q <= rx_byte;
			if (phase_q == PH_KIND || phase_q == PH_SEQ || phase_q == PH_CMD) begin
				crc_q <= crc_next;
			end
		end
	end

endmodule

>>> rtl/crc8_frame_deframer.sv
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+-----------------------------------------
// input     | in        | in_valid/in_stall  | rx_byte
// output    | out       | out_valid/out_stall| status, frame_kind, frame_seq, frame_cmd
// config    | in        | cfg_we             | cfg_index, cfg_data
//
// One request in, one result out, one request per cycle sustained while out_stall is low.
// Path: input register, then parse logic into the result register.
// arst_n clears the valid flags, the parse phase and the held frame bytes, and reloads the configuration defaults.
// A stalled result holds; the input register still takes a request while the result
// register is free or is being taken, so in_stall rises only when both are full.
module crc8_frame_deframer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [cfd_pkg::BYTE_W-1:0]     rx_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [cfd_pkg::BYTE_W-1:0]     frame_kind,
	output logic [cfd_pkg::BYTE_W-1:0]     frame_seq,
	output logic [cfd_pkg::BYTE_W-1:0]     frame_cmd,
	input  logic                           cfg_we,
	input  logic [cfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cfd_pkg::BYTE_W-1:0]     cfg_data
);
	import cfd_pkg::*;

	cfg_t cfg_q;
	logic valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic valid_s2;
	res_t res_s2;
	res_t res_d;
	logic adv;
	logic take;

	// Advance the held byte into the result register when that register is free
	// or its result is leaving this cycle.
	assign adv = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign take = in_valid && !in_stall;

	// Configuration registers; an index beyond the map is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{sync_first: RST_SYNC_FIRST, sync_second: RST_SYNC_SECOND,
				data_type_code: RST_DATA_TYPE, ack_type_code: RST_ACK_TYPE};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_FIRST: cfg_q.sync_first <= cfg_data;
				REG_SYNC_SECOND: cfg_q.sync_second <= cfg_data;
				REG_DATA_TYPE: cfg_q.data_type_code <= cfg_data;
				REG_ACK_TYPE: cfg_q.ack_type_code <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) byte_s1 <= rx_byte;
	end

	// Frame parser: phase and held bytes move only when a byte advances.
	cfd_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.res     (res_d)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_s2 <= res_d;
	end

	assign out_valid = valid_s2;
	assign status = res_s2.status;
	assign frame_kind = res_s2.kind;
	assign frame_seq = res_s2.seq;
	assign frame_cmd = res_s2.cmd;

`ifndef SYNTHESIS
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled while a stage is free");

	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |->
		(frame_kind == '0 && frame_seq == '0 && frame_cmd == '0))
		else $error("frame fields set without a good frame");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_NONE || status == ST_OK || status == ST_ERR))
		else $error("bad status code");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("advanced byte produced no result");
`endif

endmodule

>>> tb/crc8_frame_deframer_tb.sv
module crc8_frame_deframer_tb;
	import cfd_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 8;
	localparam int CYCLE_LIMIT = 200000;
	// two-stage pipe: the settle wait covers any request still in flight
	localparam int SETTLE_CYCLES = 6;
	localparam int REPORT_MAX = 10;
	localparam int LONG_HOLD = 300;
	localparam int RANDOM_BYTES = 260;

	// indexes past the register map; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

	// ------------------------------------------------------------------
	// Block ports; every input starts at a known value
	// ------------------------------------------------------------------
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [BYTE_W-1:0]    rx_byte = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           status;
	logic [BYTE_W-1:0]    frame_kind;
	logic [BYTE_W-1:0]    frame_seq;
	logic [BYTE_W-1:0]    frame_cmd;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BYTE_W-1:0]    cfg_data = '0;

	// ------------------------------------------------------------------
	// Parser shadow: configuration, hunt phase and captured frame bytes
	// ------------------------------------------------------------------
	cfg_t   shadow_cfg = '{RST_SYNC_FIRST, RST_SYNC_SECOND, RST_DATA_TYPE, RST_ACK_TYPE};
	phase_t hunt_phase = PH_SYNC_A;
	logic [BYTE_W-1:0] cap_kind = '0;
	logic [BYTE_W-1:0] cap_seq = '0;
	logic [BYTE_W-1:0] cap_cmd = '0;

	// parse results still owed by the block, oldest first
	res_t parsed_q[$];

	// idling percentages and the long receiver hold-off
	int unsigned tx_idle_pct = 22;
	int unsigned rx_idle_pct = 57;
	int unsigned hold_req = 0;
	int unsigned hold_ack = 0;
	int unsigned hold_left = 0;

	// bookkeeping
	int unsigned cycle_count = 0;
	int unsigned bytes_sent = 0;
	int unsigned frames_good = 0;
	int unsigned frames_bad = 0;
	int unsigned reg_writes = 0;
	int unsigned faults = 0;

	crc8_frame_deframer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.frame_kind(frame_kind),
		.frame_seq (frame_seq),
		.frame_cmd (frame_cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// CRC-8 over type, sequence and command, shifted in one bit at a time,
	// most significant bit first, starting from zero with no final xor
	function automatic logic [BYTE_W-1:0] frame_crc(input logic [BYTE_W-1:0] k,
			input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] c);
		logic [3*BYTE_W-1:0] msg;
		logic [BYTE_W-1:0]   acc;
		logic                fb;
		msg = {k, s, c};
		acc = CRC_INIT;
		for (int i = 3 * BYTE_W - 1; i >= 0; i--) begin
			fb = acc[BYTE_W-1] ^ msg[i];
			acc = {acc[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
		end
		return acc;
	endfunction

	// Advance the shadow parser by one byte and return what the block must report
	function automatic res_t parse_byte(input logic [BYTE_W-1:0] b);
		res_t r;
		r.status = ST_NONE;
		r.kind = '0;
		r.seq = '0;
		r.cmd = '0;
		case (hunt_phase)
			PH_SYNC_A: begin
				if (b == shadow_cfg.sync_first) begin
					hunt_phase = PH_SYNC_B;
				end
			end
			PH_SYNC_B: begin
				// second sync wins when both registers hold the same value;
				// another first sync keeps us waiting
				if (b == shadow_cfg.sync_second) begin
					hunt_phase = PH_KIND;
				end else if (b != shadow_cfg.sync_first) begin
					hunt_phase = PH_SYNC_A;
				end
			end
			PH_KIND: begin
				cap_kind = b;
				hunt_phase = PH_SEQ;
			end
			PH_SEQ: begin
				cap_seq = b;
				hunt_phase = PH_CMD;
			end
			PH_CMD: begin
				cap_cmd = b;
				hunt_phase = PH_CHECK;
			end
			PH_CHECK: begin
				hunt_phase = PH_SYNC_A;
				if (b != frame_crc(cap_kind, cap_seq, cap_cmd)) begin
					r.status = ST_ERR;
				end else if (cap_kind != shadow_cfg.data_type_code &&
						cap_kind != shadow_cfg.ack_type_code) begin
					r.status = ST_ERR;
				end else begin
					r.status = ST_OK;
					r.kind = cap_kind;
					r.seq = cap_seq;
					r.cmd = cap_cmd;
				end
			end
			default: begin
				// stray phase: recover to hunting and flag it
				hunt_phase = PH_SYNC_A;
				r.status = ST_ERR;
			end
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Receiver: random stall, or a long hold-off when one is requested
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Result checker: compare every accepted result with the oldest one owed
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.status = status_t'(status);
			got.kind = frame_kind;
			got.seq = frame_seq;
			got.cmd = frame_cmd;
			if (got.status == ST_OK) begin
				frames_good++;
			end else if (got.status == ST_ERR) begin
				frames_bad++;
			end
			if (parsed_q.size() == 0) begin
				faults++;
				if (faults <= REPORT_MAX) begin
					$display("[%0t] result with none owed: status %0d kind %02h seq %02h cmd %02h",
						$time, status, frame_kind, frame_seq, frame_cmd);
				end
			end else begin
				want = parsed_q.pop_front();
				if (got.status !== want.status || got.kind !== want.kind ||
						got.seq !== want.seq || got.cmd !== want.cmd) begin
					faults++;
					if (faults <= REPORT_MAX) begin
						$display("[%0t] mismatch: expected status %0d kind %02h seq %02h cmd %02h",
							$time, want.status, want.kind, want.seq, want.cmd);
						$display("[%0t]           actual   status %0d kind %02h seq %02h cmd %02h",
							$time, status, frame_kind, frame_seq, frame_cmd);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results still owed", cycle_count, parsed_q.size());
		$display("crc8_frame_deframer_tb NOT OK");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offer one byte, hold it until taken, then record what it must produce.
	// Valid is only dropped during a random gap, never just to be raised again.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		parsed_q.push_back(parse_byte(b));
		bytes_sent++;
	endtask

	// Stop offering and wait for every owed result to come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (parsed_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Write one register with the block idle; indexes past the map change nothing
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
		case (idx)
			REG_SYNC_FIRST: shadow_cfg.sync_first = val;
			REG_SYNC_SECOND: shadow_cfg.sync_second = val;
			REG_DATA_TYPE: shadow_cfg.data_type_code = val;
			REG_ACK_TYPE: shadow_cfg.ack_type_code = val;
			default: ;
		endcase
	endtask

	task automatic program_config(input cfg_t c);
		write_reg(REG_SYNC_FIRST, c.sync_first);
		write_reg(REG_SYNC_SECOND, c.sync_second);
		write_reg(REG_DATA_TYPE, c.data_type_code);
		write_reg(REG_ACK_TYPE, c.ack_type_code);
	endtask

	// Six-byte frame under the current sync values; crc_flip corrupts the check byte
	task automatic send_frame(input logic [BYTE_W-1:0] kind, input logic [BYTE_W-1:0] seq,
			input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] crc_flip);
		send_byte(shadow_cfg.sync_first);
		send_byte(shadow_cfg.sync_second);
		send_byte(kind);
		send_byte(seq);
		send_byte(cmd);
		send_byte(frame_crc(kind, seq, cmd) ^ crc_flip);
	endtask

	// Mostly well-formed frames with random content, the rest broken frames and noise
	task automatic send_random_chunk();
		int unsigned pick;
		int unsigned kind_pick;
		int unsigned n;
		logic [BYTE_W-1:0] kind;
		logic [BYTE_W-1:0] flip;
		pick = $urandom_range(99);
		if (pick < 70) begin
			kind_pick = $urandom_range(9);
			if (kind_pick < 4) begin
				kind = shadow_cfg.data_type_code;
			end else if (kind_pick < 8) begin
				kind = shadow_cfg.ack_type_code;
			end else begin
				kind = 8'($urandom);
			end
			flip = ($urandom_range(6) == 0) ? 8'($urandom_range(255, 1)) : '0;
			// now and then repeat the first sync byte
			if ($urandom_range(9) == 0) begin
				send_byte(shadow_cfg.sync_first);
			end
			send_frame(kind, 8'($urandom), 8'($urandom), flip);
		end else if (pick < 85) begin
			// sync followed by a wrong second byte or a truncated frame
			send_byte(shadow_cfg.sync_first);
			n = $urandom_range(4);
			repeat (n) send_byte(8'($urandom));
		end else begin
			n = $urandom_range(3, 1);
			repeat (n) send_byte(8'($urandom));
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset values: good data and ack frames, a repeated first sync, a bad
	// check byte, a broken sync pair and the byte extremes
	task automatic test_directed_frames();
		send_byte(shadow_cfg.sync_first);
		send_frame(shadow_cfg.data_type_code, 8'h00, 8'hFF, '0);
		send_frame(shadow_cfg.ack_type_code, 8'hFF, 8'h00, '0);
		send_frame(shadow_cfg.data_type_code, 8'h5A, 8'hC3, 8'h01);
		send_byte(shadow_cfg.sync_first);
		send_byte(8'h00);
		send_byte(8'hFF);
	endtask

	// Dropped writes past the map, unknown type, equal sync values, extreme registers
	task automatic test_config_edges();
		write_reg(REG_UNUSED_LO, 8'hFF);
		write_reg(REG_UNUSED_HI, 8'h00);
		send_frame(shadow_cfg.data_type_code, 8'h12, 8'h34, '0);
		send_frame(8'h7E, 8'h80, 8'h01, '0);
		write_reg(REG_SYNC_FIRST, 8'h3C);
		write_reg(REG_SYNC_SECOND, 8'h3C);
		send_frame(shadow_cfg.ack_type_code, 8'hA5, 8'h5A, '0);
		program_config('{8'h00, 8'hFF, 8'hFF, 8'h00});
		send_byte(8'h00);
		send_frame(8'hFF, 8'hFF, 8'hFF, '0);
		send_frame(8'h00, 8'h00, 8'h00, '0);
		program_config('{8'hFF, 8'h00, 8'h00, 8'hFF});
		send_frame(8'h00, 8'h7F, 8'h80, '0);
		send_frame(8'hFF, 8'h01, 8'hFE, 8'h80);
	endtask

	// Fresh random registers, then random traffic under the given idling
	task automatic test_random_traffic(input int unsigned n_bytes, input int unsigned tx_pct,
			input int unsigned rx_pct);
		int unsigned stop_at;
		cfg_t c;
		c = cfg_t'($urandom);
		program_config(c);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			send_random_chunk();
		end
	endtask

	// Hold the receiver off for a long stretch while frames keep coming, so
	// the block fills and stalls its input; then pause until all has drained and send three ack frames
	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req++;
		for (int i = 0; i < 7; i++) begin
			send_frame(shadow_cfg.data_type_code, 8'(i), 8'(~i), '0);
		end
		wait_drained();
		for (int i = 0; i < 3; i++) begin
			send_frame(shadow_cfg.ack_type_code, 8'($urandom), 8'($urandom), '0);
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_config_edges();
		test_random_traffic(RANDOM_BYTES, 22, 57);
		test_random_traffic(RANDOM_BYTES, 57, 22);
		test_random_traffic(RANDOM_BYTES, 0, 0);
		test_backpressure();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("sent %0d bytes over %0d register writes; block reported %0d good frames",
			bytes_sent, reg_writes, frames_good);
		$display("and %0d frame errors; %0d mismatches in %0d cycles",
			frames_bad, faults, cycle_count);
		if (faults == 0 && parsed_q.size() == 0) begin
			$display("crc8_frame_deframer_tb OK");
		end else begin
			$display("crc8_frame_deframer_tb NOT OK");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/cfd_pkg.sv
rtl/cfd_parse.sv
rtl/crc8_frame_deframer.sv
tb/crc8_frame_deframer_tb.sv
